### hdl/ps2mc_pkg.sv
package ps2mc_pkg;

   // Width of one byte from the mouse and of the screen size registers.
   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned SIZE_BITS = 12;

   // Configuration bus geometry.
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;

   // Register indexes on the configuration bus.
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   // Reset values of the screen size registers.
   localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd80;
   localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd25;

   // Bit positions inside the status byte.
   localparam int unsigned STATUS_LEFT_BIT   = 0;
   localparam int unsigned STATUS_RIGHT_BIT  = 1;
   localparam int unsigned STATUS_MIDDLE_BIT = 2;
   localparam int unsigned STATUS_XOVF_BIT   = 6;
   localparam int unsigned STATUS_YOVF_BIT   = 7;

   // Position of the next byte within a three byte packet.
   typedef enum logic [1:0] {
      PHASE_STATUS,
      PHASE_X_DELTA,
      PHASE_Y_DELTA
   } phase_type;

   // Decoded actions for the current byte.
   typedef struct packed {
      logic load_status;
      logic load_x_delta;
      logic emit;
   } byte_action_type;

endpackage

### hdl/ps2mc_req_if.sv
interface ps2mc_req_if
   import ps2mc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

### hdl/ps2mc_rsp_if.sv
interface ps2mc_rsp_if #(
   parameter int unsigned POS_BITS = 11
) ();
   logic                valid;
   logic                ready;
   logic [POS_BITS-1:0] cursor_x;
   logic [POS_BITS-1:0] cursor_y;
   logic                left_button;
   logic                right_button;
   logic                middle_button;
   logic                x_overflowed;
   logic                y_overflowed;

   modport source (
      output valid, output cursor_x, output cursor_y, output left_button,
      output right_button, output middle_button, output x_overflowed,
      output y_overflowed, input ready
   );
   modport sink (
      input valid, input cursor_x, input cursor_y, input left_button,
      input right_button, input middle_button, input x_overflowed,
      input y_overflowed, output ready
   );
endinterface

### hdl/ps2mc_axis_clamp.sv
module ps2mc_axis_clamp
   import ps2mc_pkg::*;
#(
   parameter int unsigned POS_BITS = 11
) (
   input  logic [POS_BITS-1:0]  pos,
   input  logic [BYTE_BITS-1:0] delta_byte,
   input  logic                 subtract,
   input  logic [SIZE_BITS-1:0] size,
   output logic [POS_BITS-1:0]  pos_next
);

   // Common working width: holds the position plus or minus a byte delta,
   // and the largest bound, with a sign bit to spare.
   localparam int unsigned CW = ((POS_BITS > SIZE_BITS) ? POS_BITS : SIZE_BITS) + 2;
   localparam logic [CW-1:0] POS_MAX_EXT = (CW'(1) << POS_BITS) - CW'(1);

   logic [CW-1:0] pos_ext;
   logic [CW-1:0] delta_ext;
   logic [CW-1:0] sum;
   logic [CW-1:0] size_m1;
   logic [CW-1:0] bound;
   logic [CW-1:0] clamped;

   // Apply the signed delta to the current position.
   always_comb begin
      pos_ext   = CW'(pos);
      delta_ext = {{(CW-BYTE_BITS){delta_byte[BYTE_BITS-1]}}, delta_byte};
      sum       = subtract ? (pos_ext - delta_ext) : (pos_ext + delta_ext);
   end

   // Upper bound is size minus one, a size of zero acting as one, and
   // never beyond the largest position.
   always_comb begin
      size_m1 = (size == '0) ? '0 : (CW'(size) - CW'(1));
      bound   = (size_m1 > POS_MAX_EXT) ? POS_MAX_EXT : size_m1;
   end

   // Clamp into the range zero through the bound.
   always_comb begin
      if (sum[CW-1]) begin
         clamped = '0;
      end else if (sum > bound) begin
         clamped = bound;
      end else begin
         clamped = sum;
      end
      pos_next = clamped[POS_BITS-1:0];
   end

endmodule

### hdl/ps2_mouse_packet_cursor_core.sv
// PS/2 mouse packet decoder with a clamped cursor.
// The request channel carries one mouse byte per word. Bytes are taken in a
// repeating order of status, X delta and Y delta. The status and X delta
// bytes produce no response; the Y delta byte updates the cursor and sends
// one response word with the clamped position and the held button and
// overflow flags.
// Latency: the response word is valid in the cycle after the Y delta byte
// is accepted. Throughput: one byte per cycle while the response register
// is free or being taken; the cursor update feeds a single response register.
// The APB port holds the screen width (address 0) and height (address 4).
// The cursor is clamped to 0 .. size-1 on each axis, a size of zero acting as one, capped at the largest position.
// Reset returns the packet phase to the status byte, sets the cursor to
// column 5, row 2 and the screen size to 80 by 25, and drops any pending
// response. While the receiver stalls, the response holds and a new byte is
// accepted only when the response register is empty or being taken.
module ps2_mouse_packet_cursor_core
   import ps2mc_pkg::*;
#(
   parameter int unsigned POS_BITS = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   ps2mc_req_if.sink                req_bus,
   ps2mc_rsp_if.source              rsp_bus,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam logic [POS_BITS-1:0] POS_MAX   = {POS_BITS{1'b1}};
   localparam logic [POS_BITS-1:0] POS_X_RST = POS_BITS'(5) & POS_MAX;
   localparam logic [POS_BITS-1:0] POS_Y_RST = POS_BITS'(2) & POS_MAX;

   logic [SIZE_BITS-1:0] screen_width_ff;
   logic [SIZE_BITS-1:0] screen_height_ff;
   logic                 csr_write;
   logic                 csr_index;

   phase_type            phase_ff;
   phase_type            phase_in;
   byte_action_type      action;
   logic [BYTE_BITS-1:0] status_hold_ff;
   logic [BYTE_BITS-1:0] x_delta_hold_ff;
   logic [POS_BITS-1:0]  pos_x_ff;
   logic [POS_BITS-1:0]  pos_y_ff;
   logic [POS_BITS-1:0]  pos_x_in;
   logic [POS_BITS-1:0]  pos_y_in;

   logic                 req_fire;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [POS_BITS-1:0]  rsp_x_ff;
   logic [POS_BITS-1:0]  rsp_y_ff;
   logic [BYTE_BITS-1:0] rsp_status_ff;

   // Configuration access; writes complete in the access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[2];

   always_comb begin
      unique case (csr_index)
         REG_SCREEN_WIDTH:  prdata = CSR_DATA_BITS'(screen_width_ff);
         REG_SCREEN_HEIGHT: prdata = CSR_DATA_BITS'(screen_height_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  screen_width_ff  <= pwdata[SIZE_BITS-1:0];
            REG_SCREEN_HEIGHT: screen_height_ff <= pwdata[SIZE_BITS-1:0];
            default:           screen_width_ff  <= screen_width_ff;
         endcase
      end
   end

   // A byte is taken when the response register is free or draining.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Packet phase: next state.
   always_comb begin
      unique case (phase_ff)
         PHASE_X_DELTA: phase_in = PHASE_Y_DELTA;
         PHASE_Y_DELTA: phase_in = PHASE_STATUS;
         default:       phase_in = PHASE_X_DELTA;
      endcase
   end

   // Packet phase: decoded actions for the current byte.
   always_comb begin
      action = '0;
      unique case (phase_ff)
         PHASE_X_DELTA: action.load_x_delta = 1'b1;
         PHASE_Y_DELTA: action.emit         = 1'b1;
         default:       action.load_status  = 1'b1;
      endcase
   end

   // Cursor update on each axis; Y moves opposite to the mouse delta.
   ps2mc_axis_clamp #(.POS_BITS(POS_BITS)) u_clamp_x (
      .pos        (pos_x_ff),
      .delta_byte (x_delta_hold_ff),
      .subtract   (1'b0),
      .size       (screen_width_ff),
      .pos_next   (pos_x_in)
   );

   ps2mc_axis_clamp #(.POS_BITS(POS_BITS)) u_clamp_y (
      .pos        (pos_y_ff),
      .delta_byte (req_bus.data_byte),
      .subtract   (1'b1),
      .size       (screen_height_ff),
      .pos_next   (pos_y_in)
   );

   // Control state: phase, cursor and response valid.
   assign rsp_valid_in = (req_fire && action.emit) || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_STATUS;
         status_hold_ff  <= '0;
         x_delta_hold_ff <= '0;
         pos_x_ff        <= POS_X_RST;
         pos_y_ff        <= POS_Y_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff <= phase_in;
            if (action.load_status) begin
               status_hold_ff <= req_bus.data_byte;
            end
            if (action.load_x_delta) begin
               x_delta_hold_ff <= req_bus.data_byte;
            end
            if (action.emit) begin
               pos_x_ff <= pos_x_in;
               pos_y_ff <= pos_y_in;
            end
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (req_fire && action.emit) begin
         rsp_x_ff      <= pos_x_in;
         rsp_y_ff      <= pos_y_in;
         rsp_status_ff <= status_hold_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.cursor_x      = rsp_x_ff;
   assign rsp_bus.cursor_y      = rsp_y_ff;
   assign rsp_bus.left_button   = rsp_status_ff[STATUS_LEFT_BIT];
   assign rsp_bus.right_button  = rsp_status_ff[STATUS_RIGHT_BIT];
   assign rsp_bus.middle_button = rsp_status_ff[STATUS_MIDDLE_BIT];
   assign rsp_bus.x_overflowed  = rsp_status_ff[STATUS_XOVF_BIT];
   assign rsp_bus.y_overflowed  = rsp_status_ff[STATUS_YOVF_BIT];

endmodule

### dv/ps2_mouse_packet_cursor_core_tb.sv
import ps2mc_pkg::*;

localparam int unsigned CURSOR_BITS = 11;

// One response word from the cursor block.
typedef struct packed {
   logic [CURSOR_BITS-1:0] cursor_x;
   logic [CURSOR_BITS-1:0] cursor_y;
   logic                   left_button;
   logic                   right_button;
   logic                   middle_button;
   logic                   x_overflowed;
   logic                   y_overflowed;
} cursor_word_type;

// Tracks the packet phase, held bytes and cursor position, and keeps the
// cursor words that the block still owes.
class cursor_tracker;
   phase_type            phase;
   logic [BYTE_BITS-1:0] status_hold;
   logic [BYTE_BITS-1:0] x_delta_byte;
   logic [CURSOR_BITS-1:0] col;
   logic [CURSOR_BITS-1:0] row;
   logic [SIZE_BITS-1:0] width_reg;
   logic [SIZE_BITS-1:0] height_reg;
   cursor_word_type      owed_words[$];
   int unsigned          mismatches;

   function new();
      phase        = PHASE_STATUS;
      status_hold  = '0;
      x_delta_byte = '0;
      col          = CURSOR_BITS'(5);
      row          = CURSOR_BITS'(2);
      width_reg    = SCREEN_WIDTH_RESET;
      height_reg   = SCREEN_HEIGHT_RESET;
      mismatches   = 0;
   endfunction

   function void set_size(logic idx, logic [CSR_DATA_BITS-1:0] value);
      if (idx == REG_SCREEN_WIDTH) begin
         width_reg = value[SIZE_BITS-1:0];
      end else begin
         height_reg = value[SIZE_BITS-1:0];
      end
   endfunction

   // A size of zero behaves as one, and the bound never exceeds the
   // position range.
   function logic [CURSOR_BITS-1:0] clamp_axis(int v, logic [SIZE_BITS-1:0] size);
      int top;
      top = (size == 0) ? 0 : int'(size) - 1;
      if (top > (1 << CURSOR_BITS) - 1) top = (1 << CURSOR_BITS) - 1;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v[CURSOR_BITS-1:0];
   endfunction

   function void note_byte(logic [BYTE_BITS-1:0] b);
      int              dx;
      int              dy;
      cursor_word_type word;
      case (phase)
         PHASE_X_DELTA: begin
            x_delta_byte = b;
            phase = PHASE_Y_DELTA;
         end
         PHASE_Y_DELTA: begin
            dx = $signed(x_delta_byte);
            dy = $signed(b);
            col = clamp_axis(int'(col) + dx, width_reg);
            row = clamp_axis(int'(row) - dy, height_reg);
            word.cursor_x      = col;
            word.cursor_y      = row;
            word.left_button   = status_hold[STATUS_LEFT_BIT];
            word.right_button  = status_hold[STATUS_RIGHT_BIT];
            word.middle_button = status_hold[STATUS_MIDDLE_BIT];
            word.x_overflowed  = status_hold[STATUS_XOVF_BIT];
            word.y_overflowed  = status_hold[STATUS_YOVF_BIT];
            owed_words.push_back(word);
            phase = PHASE_STATUS;
         end
         default: begin
            status_hold = b;
            phase = PHASE_X_DELTA;
         end
      endcase
   endfunction

   function void check_word(cursor_word_type got);
      cursor_word_type want;
      if (owed_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected cursor word: x=%0d y=%0d btn(lrm)=%b%b%b ovf(xy)=%b%b",
                     got.cursor_x, got.cursor_y, got.left_button, got.right_button,
                     got.middle_button, got.x_overflowed, got.y_overflowed);
         return;
      end
      want = owed_words.pop_front();
      if (got.cursor_x != want.cursor_x || got.cursor_y != want.cursor_y ||
          got.left_button != want.left_button || got.right_button != want.right_button ||
          got.middle_button != want.middle_button ||
          got.x_overflowed != want.x_overflowed || got.y_overflowed != want.y_overflowed)
      begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("cursor word mismatch: expected x=%0d y=%0d btn(lrm)=%b%b%b ovf(xy)=%b%b",
                     want.cursor_x, want.cursor_y, want.left_button, want.right_button,
                     want.middle_button, want.x_overflowed, want.y_overflowed);
            $display("                      got      x=%0d y=%0d btn(lrm)=%b%b%b ovf(xy)=%b%b",
                     got.cursor_x, got.cursor_y, got.left_button, got.right_button,
                     got.middle_button, got.x_overflowed, got.y_overflowed);
         end
      end
   endfunction

   function int owed();
      return owed_words.size();
   endfunction
endclass

module ps2_mouse_packet_cursor_core_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 400;
   localparam int PHASES      = 10;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   ps2mc_req_if                                 req_bus ();
   ps2mc_rsp_if #(.POS_BITS(CURSOR_BITS))       rsp_bus ();

   ps2_mouse_packet_cursor_core #(.POS_BITS(CURSOR_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   cursor_tracker tracker = new();

   int  cycle_count = 0;
   int  stall_left  = 0;
   bit  src_calm    = 0;
   bit  sink_calm   = 0;
   bit  hold_request = 0;
   bit  sink_hold   = 0;

   // Directed packets: every status bit, delta extremes and clamps at both
   // ends of the default screen.
   byte unsigned directed_bytes [27] = '{
      8'h00, 8'h00, 8'h00,
      8'h01, 8'h7F, 8'h80,
      8'h02, 8'h80, 8'h7F,
      8'h04, 8'h01, 8'hFF,
      8'h08, 8'hFF, 8'h01,
      8'h10, 8'h10, 8'hF0,
      8'h20, 8'h40, 8'hC0,
      8'h40, 8'h80, 8'h40,
      8'hFF, 8'h81, 8'h7E
   };

   // Clock generator.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Cycle counter that ends a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ps2_mouse_packet_cursor_core verification failed");
         $finish;
      end
   end

   // Mostly short idle stretches, with a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one mouse byte after an optional gap and wait until it is taken.
   task automatic send_byte(input logic [BYTE_BITS-1:0] b);
      int gap;
      gap = src_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_byte(b);
      @(negedge clock);
   endtask

   // Stop offering and let every owed word drain before touching registers.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.owed() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready, then psel and
   // penable drop before the task returns.
   task automatic csr_write(input logic idx, input logic [SIZE_BITS-1:0] size);
      logic [CSR_DATA_BITS-1:0] value;
      value = {($urandom_range(0, 1) ? 20'($urandom) : 20'd0), size};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_size(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver readiness with random stalls and an occasional forced hold.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 5) == 0) stall_left = pick_gap();
         end
      end
   end

   // Long receiver hold so that the response register fills and the
   // block stops taking bytes.
   initial begin
      wait (hold_request);
      sink_hold = 1'b1;
      repeat (LONG_HOLD) @(negedge clock);
      sink_hold = 1'b0;
   end

   // Check every accepted response word.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_word('{rsp_bus.cursor_x, rsp_bus.cursor_y, rsp_bus.left_button,
                              rsp_bus.right_button, rsp_bus.middle_button,
                              rsp_bus.x_overflowed, rsp_bus.y_overflowed});
   end

   // Main sequence.
   initial begin
      logic [SIZE_BITS-1:0] w;
      logic [SIZE_BITS-1:0] h;
      bit                   drift_x;
      bit                   drift_y;
      logic [BYTE_BITS-1:0] dx;
      logic [BYTE_BITS-1:0] dy;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset screen size.
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         // Screen size for this phase: extremes first, then random sizes.
         case (p)
            0: begin w = 12'd1;    h = 12'd1;    end
            1: begin w = 12'd0;    h = 12'd0;    end
            2: begin w = 12'd4095; h = 12'd4095; end
            3: begin w = 12'd2048; h = 12'd2048; end
            4: begin w = 12'd2047; h = 12'd1;    end
            default: begin
               w = $urandom_range(0, 1) ? 12'($urandom_range(1, 64))
                                        : 12'($urandom_range(1, 2048));
               h = $urandom_range(0, 1) ? 12'($urandom_range(1, 64))
                                        : 12'($urandom_range(1, 2048));
            end
         endcase
         csr_write(REG_SCREEN_WIDTH, w);
         csr_write(REG_SCREEN_HEIGHT, h);

         src_calm  = (p == 6) || (p % 4 == 1);
         sink_calm = (p % 4 == 3);
         if (p == 6) hold_request = 1'b1;

         // Packets with random content, biased toward full-speed drift so
         // that large screens reach their edges.
         drift_x = 1'($urandom_range(0, 1));
         drift_y = 1'($urandom_range(0, 1));
         for (int k = 0; k < 61; k++) begin
            if (k % 25 == 24) begin
               drift_x = 1'($urandom_range(0, 1));
               drift_y = 1'($urandom_range(0, 1));
            end
            dx = ($urandom_range(0, 2) == 0) ? (drift_x ? 8'h7F : 8'h80) : 8'($urandom);
            dy = ($urandom_range(0, 2) == 0) ? (drift_y ? 8'h7F : 8'h80) : 8'($urandom);
            send_byte(8'($urandom));
            send_byte(dx);
            send_byte(dy);
         end
         // Up to two stray bytes so that size changes land mid-packet too.
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
         drain();
      end

      while (tracker.owed() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.owed() == 0) begin
         $display("ps2_mouse_packet_cursor_core verification clean");
      end else begin
         $display("ps2_mouse_packet_cursor_core verification failed");
      end
      $finish;
   end

endmodule
